// ===== sv/bmprle_pkg.sv =====
// ----------------------------------------------------------------------------
// bmprle_pkg: shared types and constants of the bitmap RLE stream decoder
// Result kinds, configuration register indexes, cursor and row formats,
// and the structs passed between the top level and the parser.
// ----------------------------------------------------------------------------
`default_nettype none

package bmprle_pkg;

	// Result kinds
	localparam logic [1:0] KIND_RUN     = 2'd0;
	localparam logic [1:0] KIND_END     = 2'd1;
	localparam logic [1:0] KIND_CORRUPT = 2'd2;

	// Configuration register indexes
	localparam logic [1:0] CFG_FOUR_BIT_MODE = 2'd0;
	localparam logic [1:0] CFG_ROW_PITCH     = 2'd1;
	localparam logic [1:0] CFG_FRAME_ROWS    = 2'd2;

	localparam int CFG_DATA_W = 11;
	localparam logic [CFG_DATA_W-1:0] CFG_DIM_RESET = 11'd1024;

	// Cursor saturates at +-2^40, row number at -2^20
	localparam int CUR_W = 42;
	localparam int ROW_W = 22;
	localparam logic signed [CUR_W-1:0] CUR_LIMIT = 42'sh100_0000_0000;
	localparam logic signed [CUR_W-1:0] CUR_FLOOR = -42'sh100_0000_0000;
	localparam logic signed [ROW_W-1:0] ROW_FLOOR = -22'sd1048576;

	// Stream restart request (reset values after a register write)
	typedef struct packed {
		logic             go;
		logic [ROW_W-1:0] row;
		logic [CUR_W-1:0] cursor;
	} restart_t;

	// One decoded result
	typedef struct packed {
		logic       valid;
		logic [1:0] kind;
		logic [19:0] addr;
		logic [7:0] len;
		logic [7:0] even;
		logic [7:0] odd;
	} result_t;

endpackage

`default_nettype wire

// ===== sv/bmprle_parser.sv =====
// ----------------------------------------------------------------------------
// bmprle_parser: RLE8/RLE4 grammar walker and run clipper
// Holds the parse phase, counts, cursor and row; consumes one byte per step
// and produces at most one result, computed combinationally from its state.
// ----------------------------------------------------------------------------
`default_nettype none

module bmprle_parser #(
	parameter int MAX_PITCH = 1024,
	parameter int MAX_ROWS  = 1024
) (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire bmprle_pkg::restart_t restart,
	input  wire                       step,
	input  wire [7:0]                 code_byte,
	input  wire                       stream_end,
	input  wire                       four_bit,
	input  wire [$clog2(MAX_PITCH+1)-1:0] eff_pitch,
	input  wire [$clog2(MAX_PITCH*MAX_ROWS+1)-1:0] frame_end,
	output bmprle_pkg::result_t       res
);

	localparam int PW = $clog2(MAX_PITCH + 1);
	localparam int CW = bmprle_pkg::CUR_W;
	localparam int RWD = bmprle_pkg::ROW_W;
	localparam int RST_ROWS  = (MAX_ROWS < 1024) ? MAX_ROWS : 1024;
	localparam int RST_PITCH = (MAX_PITCH < 1024) ? MAX_PITCH : 1024;
	localparam logic signed [RWD-1:0] RST_ROW = RWD'(RST_ROWS - 1);
	localparam logic signed [CW-1:0] RST_CURSOR = CW'((RST_ROWS - 1) * RST_PITCH);

	localparam logic [7:0] ESC_EOL   = 8'd0;
	localparam logic [7:0] ESC_END   = 8'd1;
	localparam logic [7:0] ESC_DELTA = 8'd2;

	typedef enum logic [2:0] {
		PH_COUNT, PH_COLOR, PH_ESCAPE, PH_DX, PH_DY, PH_ABS, PH_PAD
	} phase_t;

	phase_t                 phase_q, phase_d;
	logic [7:0]             count_q, count_d;
	logic                   pad_q, pad_d;
	logic signed [CW-1:0]   cursor_q, cursor_d;
	logic signed [RWD-1:0]  row_q, row_d;
	logic                   done_q, done_d;

	// Span: pixels a run of span_c advances the cursor
	logic                   abs_pair;
	logic [7:0]             span_c;
	logic signed [CW-1:0]   rem;
	logic [8:0]             rem_sat;
	logic [8:0]             n8;
	logic [6:0]             pairs;
	logic [8:0]             n4;
	logic [8:0]             span_n;

	// Emit: clip against frame start, fix up nibble phase
	logic signed [CW-1:0]   emit_next;
	logic                   cur_neg;
	logic                   emit_hit;
	logic [7:0]             emit_len;
	logic [7:0]             v_hi, v_lo, v_second;
	logic [7:0]             emit_even, emit_odd;

	// Row and cursor moves
	logic signed [RWD-1:0]  row_dec;
	logic signed [RWD+PW:0] eol_prod;
	logic signed [CW-1:0]   dx_sum;
	logic [8+PW-1:0]        dy_prod;
	logic signed [CW-1:0]   dy_diff, dy_cursor;
	logic signed [RWD-1:0]  dy_row;
	logic [8:0]             abs_pad_sum;
	logic                   bad;

	// Span computation
	assign abs_pair = four_bit && (count_q >= 8'd2);
	assign span_c   = (phase_q == PH_COLOR) ? count_q : (abs_pair ? 8'd2 : 8'd1);
	assign rem      = $signed(CW'(frame_end)) - cursor_q;

	always_comb begin
		if (rem <= 0) begin
			rem_sat = 9'd0;
		end else if (rem > 511) begin
			rem_sat = 9'd511;
		end else begin
			rem_sat = rem[8:0];
		end
	end

	assign n8    = ({1'b0, span_c} < rem_sat) ? {1'b0, span_c} : rem_sat;
	assign pairs = ({1'b0, span_c[7:1]} < rem_sat[8:1]) ? span_c[7:1] : rem_sat[7:1];
	assign n4    = {1'b0, pairs, 1'b0} + 9'((span_c[0] && ({1'b0, pairs, 1'b0} < rem_sat)) ? 1 : 0);
	assign span_n = four_bit ? n4 : n8;

	// Emit computation
	assign emit_next = cursor_q + $signed(CW'(span_n));
	assign cur_neg   = cursor_q < 0;
	assign emit_hit  = cur_neg ? (emit_next > 0) : (span_n != 9'd0);
	assign emit_len  = cur_neg ? emit_next[7:0] : span_n[7:0];

	assign v_hi     = four_bit ? {4'b0, code_byte[7:4]} : code_byte;
	assign v_lo     = four_bit ? {4'b0, code_byte[3:0]} : code_byte;
	assign v_second = (phase_q == PH_ABS && four_bit && !abs_pair) ? v_hi : v_lo;

	always_comb begin
		if (cur_neg && cursor_q[0]) begin
			emit_even = v_second;
			emit_odd  = v_hi;
		end else begin
			emit_even = v_hi;
			emit_odd  = v_second;
		end
		if (emit_len == 8'd1) begin
			emit_odd = emit_even;
		end
	end

	// End of line, delta and absolute-run helpers
	assign row_dec  = (row_q == bmprle_pkg::ROW_FLOOR) ? row_q : row_q - RWD'(1);
	assign eol_prod = row_dec * $signed({1'b0, eff_pitch});
	assign dx_sum   = cursor_q + $signed(CW'(code_byte));
	assign dy_prod  = code_byte * eff_pitch;
	assign dy_diff  = cursor_q - $signed(CW'(dy_prod));
	assign dy_cursor = (dy_diff < bmprle_pkg::CUR_FLOOR) ? bmprle_pkg::CUR_FLOOR : dy_diff;
	assign dy_row   = ((row_q - $signed(RWD'(code_byte))) < bmprle_pkg::ROW_FLOOR) ?
		bmprle_pkg::ROW_FLOOR : row_q - $signed(RWD'(code_byte));
	assign abs_pad_sum = {1'b0, code_byte} + 9'd1;

	// Next state and result
	always_comb begin
		phase_d  = phase_q;
		count_d  = count_q;
		pad_d    = pad_q;
		cursor_d = cursor_q;
		row_d    = row_q;
		done_d   = done_q;
		bad      = 1'b0;
		res      = '0;
		if (step && !done_q) begin
			case (phase_q)
				PH_COUNT: begin
					if (code_byte != 8'd0) begin
						if (row_q < 0) begin
							bad = 1'b1;
						end else begin
							count_d = code_byte;
							phase_d = PH_COLOR;
						end
					end else begin
						phase_d = PH_ESCAPE;
					end
				end
				PH_COLOR: begin
					cursor_d = emit_next;
					count_d  = 8'd0;
					phase_d  = PH_COUNT;
					if (emit_hit) begin
						res.valid = 1'b1;
						res.kind  = bmprle_pkg::KIND_RUN;
						res.addr  = cur_neg ? 20'd0 : cursor_q[19:0];
						res.len   = emit_len;
						res.even  = emit_even;
						res.odd   = emit_odd;
					end
				end
				PH_ESCAPE: begin
					case (code_byte)
						ESC_EOL: begin
							row_d    = row_dec;
							cursor_d = CW'(eol_prod);
							phase_d  = PH_COUNT;
						end
						ESC_END: begin
							done_d    = 1'b1;
							phase_d   = PH_COUNT;
							res.valid = 1'b1;
							res.kind  = bmprle_pkg::KIND_END;
						end
						ESC_DELTA: begin
							phase_d = PH_DX;
						end
						default: begin
							count_d = code_byte;
							pad_d   = four_bit ? abs_pad_sum[1] : code_byte[0];
							phase_d = PH_ABS;
						end
					endcase
				end
				PH_DX: begin
					cursor_d = (dx_sum > bmprle_pkg::CUR_LIMIT) ? bmprle_pkg::CUR_LIMIT : dx_sum;
					phase_d  = PH_DY;
				end
				PH_DY: begin
					cursor_d = dy_cursor;
					row_d    = dy_row;
					phase_d  = PH_COUNT;
					if (dy_cursor < 0) begin
						bad = 1'b1;
					end
				end
				PH_ABS: begin
					cursor_d = emit_next;
					if (abs_pair) begin
						count_d = count_q - 8'd2;
					end else if (four_bit) begin
						count_d = 8'd0;
					end else begin
						count_d = (count_q != 8'd0) ? count_q - 8'd1 : 8'd0;
					end
					if (count_d == 8'd0) begin
						phase_d = pad_q ? PH_PAD : PH_COUNT;
					end
					if (emit_hit) begin
						res.valid = 1'b1;
						res.kind  = bmprle_pkg::KIND_RUN;
						res.addr  = cur_neg ? 20'd0 : cursor_q[19:0];
						res.len   = emit_len;
						res.even  = emit_even;
						res.odd   = emit_odd;
					end
				end
				PH_PAD: begin
					pad_d   = 1'b0;
					phase_d = PH_COUNT;
				end
				default: begin
					phase_d = PH_COUNT;
				end
			endcase
			// early end of stream overrides any run of this byte
			if (stream_end && !done_d) begin
				bad = 1'b1;
			end
			if (bad) begin
				done_d    = 1'b1;
				res       = '0;
				res.valid = 1'b1;
				res.kind  = bmprle_pkg::KIND_CORRUPT;
			end
		end
	end

	// State registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_COUNT;
			count_q  <= 8'd0;
			pad_q    <= 1'b0;
			cursor_q <= RST_CURSOR;
			row_q    <= RST_ROW;
			done_q   <= 1'b0;
		end else if (restart.go) begin
			phase_q  <= PH_COUNT;
			count_q  <= 8'd0;
			pad_q    <= 1'b0;
			cursor_q <= $signed(restart.cursor);
			row_q    <= $signed(restart.row);
			done_q   <= 1'b0;
		end else begin
			phase_q  <= phase_d;
			count_q  <= count_d;
			pad_q    <= pad_d;
			cursor_q <= cursor_d;
			row_q    <= row_d;
			done_q   <= done_d;
		end
	end

endmodule

`default_nettype wire

// ===== sv/bmp_rle_stream_decoder.sv =====
// ----------------------------------------------------------------------------
// bmp_rle_stream_decoder: bitmap RLE8/RLE4 stream to run descriptors
// Pipeline: a transferred byte waits in the input register until it steps
// the parser, which stores its result in the result register.
// Throughput: one byte per cycle while the result stage is free or drains.
// Reset: arst_n clears all control state; config returns to RLE8, 1024x1024.
// A write to indexes 0-2 restarts stream state; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module bmp_rle_stream_decoder #(
	parameter int MAX_PITCH = 1024,
	parameter int MAX_ROWS  = 1024
) (
	input  wire        clk,
	input  wire        arst_n,
	// configuration
	input  wire        cfg_write_en,
	input  wire [1:0]  cfg_index,
	input  wire [10:0] cfg_data,
	// compressed byte input
	input  wire        in_valid,
	output logic       in_ready,
	input  wire [7:0]  code_byte,
	input  wire        stream_end,
	// result output
	output logic       out_valid,
	input  wire        out_ready,
	output logic [1:0] result_kind,
	output logic [19:0] pixel_address,
	output logic [7:0] run_length,
	output logic [7:0] even_value,
	output logic [7:0] odd_value
);

	localparam int PW = $clog2(MAX_PITCH + 1);
	localparam int RW = $clog2(MAX_ROWS + 1);
	localparam int EW = $clog2(MAX_PITCH * MAX_ROWS + 1);
	localparam int RST_ROWS  = (MAX_ROWS < 1024) ? MAX_ROWS : 1024;
	localparam int RST_PITCH = (MAX_PITCH < 1024) ? MAX_PITCH : 1024;

	// Configuration registers (effective, clipped values)
	logic          four_bit_q, four_bit_d;
	logic [PW-1:0] pitch_q, pitch_d;
	logic [RW-1:0] rows_q, rows_d;
	logic [EW-1:0] end_q;
	logic          cfg_hit;
	logic [PW-1:0] pitch_clip;
	logic [RW-1:0] rows_clip;
	logic [RW+PW-1:0] end_prod, start_prod;
	bmprle_pkg::restart_t restart;

	// Pipeline
	logic       valid_s1;
	logic [7:0] code_s1;
	logic       end_s1;
	logic       advance;
	bmprle_pkg::result_t step_res;
	bmprle_pkg::result_t res_s2;

	// Clip written dimensions
	always_comb begin
		if (cfg_data == 11'd0) begin
			pitch_clip = PW'(1);
		end else if (int'(cfg_data) > MAX_PITCH) begin
			pitch_clip = PW'(MAX_PITCH);
		end else begin
			pitch_clip = PW'(cfg_data);
		end
		if (cfg_data == 11'd0) begin
			rows_clip = RW'(1);
		end else if (int'(cfg_data) > MAX_ROWS) begin
			rows_clip = RW'(MAX_ROWS);
		end else begin
			rows_clip = RW'(cfg_data);
		end
	end

	// Decode a register write
	always_comb begin
		four_bit_d = four_bit_q;
		pitch_d    = pitch_q;
		rows_d     = rows_q;
		cfg_hit    = 1'b0;
		if (cfg_write_en) begin
			case (cfg_index)
				bmprle_pkg::CFG_FOUR_BIT_MODE: begin
					four_bit_d = cfg_data[0];
					cfg_hit    = 1'b1;
				end
				bmprle_pkg::CFG_ROW_PITCH: begin
					pitch_d = pitch_clip;
					cfg_hit = 1'b1;
				end
				bmprle_pkg::CFG_FRAME_ROWS: begin
					rows_d  = rows_clip;
					cfg_hit = 1'b1;
				end
				default: begin
					cfg_hit = 1'b0;
				end
			endcase
		end
	end

	// Frame size and bottom-row start for the new configuration
	assign end_prod   = rows_d * pitch_d;
	assign start_prod = (rows_d - RW'(1)) * pitch_d;

	assign restart.go     = cfg_hit;
	assign restart.row    = bmprle_pkg::ROW_W'(rows_d - RW'(1));
	assign restart.cursor = bmprle_pkg::CUR_W'(start_prod[EW-1:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			four_bit_q <= 1'b0;
			pitch_q    <= PW'(RST_PITCH);
			rows_q     <= RW'(RST_ROWS);
			end_q      <= EW'(RST_PITCH * RST_ROWS);
		end else if (cfg_hit) begin
			four_bit_q <= four_bit_d;
			pitch_q    <= pitch_d;
			rows_q     <= rows_d;
			end_q      <= end_prod[EW-1:0];
		end
	end

	// Handshake: stage 1 moves on when the result stage is free or drains
	assign advance  = valid_s1 && (!res_s2.valid || out_ready);
	assign in_ready = !valid_s1 || advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			code_s1 <= code_byte;
			end_s1  <= stream_end;
		end
	end

	bmprle_parser #(
		.MAX_PITCH (MAX_PITCH),
		.MAX_ROWS  (MAX_ROWS)
	) u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.restart    (restart),
		.step       (advance),
		.code_byte  (code_s1),
		.stream_end (end_s1),
		.four_bit   (four_bit_q),
		.eff_pitch  (pitch_q),
		.frame_end  (end_q),
		.res        (step_res)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_s2 <= '0;
		end else if (advance) begin
			res_s2 <= step_res;
		end else if (out_ready) begin
			res_s2.valid <= 1'b0;
		end
	end

	assign out_valid     = res_s2.valid;
	assign result_kind   = res_s2.kind;
	assign pixel_address = res_s2.addr;
	assign run_length    = res_s2.len;
	assign even_value    = res_s2.even;
	assign odd_value     = res_s2.odd;

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the bitmap RLE8/RLE4 stream decoder
// Streams compressed bytes into the decoder and checks every descriptor it
// emits against a cycle-free decoder model kept in the bench. A short table
// of directed bytes runs first, then random well-formed streams with noise,
// early ends and clipping, over a range of frame shapes in both modes.
// ----------------------------------------------------------------------------

module tb;
	import bmprle_pkg::*;

	localparam int     MAX_PITCH    = 1024;
	localparam int     MAX_ROWS     = 1024;
	localparam int     CYCLE_LIMIT  = 200000;
	localparam int     DRAIN_CYCLES = 8;
	localparam int     HOLD_CYCLES  = 300;
	localparam int     PHASE_ITEMS  = 270;
	localparam longint CUR_SAT      = longint'(CUR_LIMIT);
	localparam longint ROW_SAT      = longint'(ROW_FLOOR);

	// Stream grammar codes
	localparam logic [7:0] RLE_ESCAPE = 8'd0;
	localparam logic [7:0] ESC_EOL    = 8'd0;
	localparam logic [7:0] ESC_EOB    = 8'd1;
	localparam logic [7:0] ESC_DELTA  = 8'd2;
	localparam logic [1:0] CFG_UNUSED = 2'd3;

	typedef enum logic [2:0] {
		P_COUNT, P_COLOR, P_ESCAPE, P_DX, P_DY, P_ABS, P_PAD
	} parse_phase_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [19:0] addr;
		logic [7:0]  len;
		logic [7:0]  even;
		logic [7:0]  odd;
	} run_desc_t;

	typedef struct packed {
		logic [7:0] b;
		logic       last;
		bit         typed;
		bit         has;
		run_desc_t  want;
	} plan_row_t;

	logic        clk          = 1'b0;
	logic        arst_n       = 1'b0;
	logic        cfg_write_en = 1'b0;
	logic [1:0]  cfg_index    = '0;
	logic [10:0] cfg_data     = '0;
	logic        in_valid     = 1'b0;
	logic        in_ready;
	logic [7:0]  code_byte    = '0;
	logic        stream_end   = 1'b0;
	logic        out_valid;
	logic        out_ready    = 1'b0;
	logic [1:0]  result_kind;
	logic [19:0] pixel_address;
	logic [7:0]  run_length;
	logic [7:0]  even_value;
	logic [7:0]  odd_value;

	bmp_rle_stream_decoder #(
		.MAX_PITCH(MAX_PITCH),
		.MAX_ROWS (MAX_ROWS)
	) u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write_en (cfg_write_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.code_byte    (code_byte),
		.stream_end   (stream_end),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.result_kind  (result_kind),
		.pixel_address(pixel_address),
		.run_length   (run_length),
		.even_value   (even_value),
		.odd_value    (odd_value)
	);

	always #2 clk = ~clk;

	// Decoder model state and its copy of the registers
	bit           nib_mode;
	logic [10:0]  pitch_reg;
	logic [10:0]  rows_reg;
	parse_phase_t phase;
	int unsigned  pend;
	bit           pad_due;
	longint       cursor;
	longint       row;
	bit           done;

	run_desc_t expected_runs[$];
	int        mismatches = 0;
	int        cycles     = 0;
	int        bytes_decoded = 0;
	int        cfg_sets   = 0;
	int        run_count  = 0;
	int        end_count  = 0;
	int        corrupt_count = 0;
	int        send_idle_pct = 0;
	int        recv_idle_pct = 0;
	logic      hold_req   = 1'b0;

	function automatic longint eff_pitch();
		if (pitch_reg == 0) return 1;
		if (pitch_reg > MAX_PITCH) return MAX_PITCH;
		return longint'(pitch_reg);
	endfunction

	function automatic longint eff_rows();
		if (rows_reg == 0) return 1;
		if (rows_reg > MAX_ROWS) return MAX_ROWS;
		return longint'(rows_reg);
	endfunction

	function automatic longint clamp_cursor(longint v);
		if (v > CUR_SAT) return CUR_SAT;
		if (v < -CUR_SAT) return -CUR_SAT;
		return v;
	endfunction

	function automatic void restart_stream();
		phase   = P_COUNT;
		pend    = 0;
		pad_due = 1'b0;
		row     = eff_rows() - 1;
		cursor  = row * eff_pitch();
		done    = 1'b0;
	endfunction

	// Pixels the cursor moves for a run of c pixels (frame-end clipping)
	function automatic longint pixels_fitting(int unsigned c, bit nib);
		longint lim;
		longint pairs;
		longint room;
		longint n;
		lim = eff_pitch() * eff_rows();
		if (!nib) begin
			if (cursor >= lim) return 0;
			return (longint'(c) < lim - cursor) ? longint'(c) : lim - cursor;
		end
		pairs = 0;
		if (cursor < lim - 1) begin
			room  = (lim - cursor) / 2;
			pairs = (longint'(c >> 1) < room) ? longint'(c >> 1) : room;
		end
		n = 2 * pairs;
		if ((c & 1) != 0 && cursor + n < lim) n++;
		return n;
	endfunction

	// Clips n pixels from the cursor to the frame, advances the cursor
	function automatic bit place_run(longint n, logic [7:0] v0, logic [7:0] v1,
			output run_desc_t r);
		longint     lim;
		longint     s;
		longint     lo;
		longint     hi;
		logic [7:0] t;
		r      = '0;
		lim    = eff_pitch() * eff_rows();
		s      = cursor;
		lo     = (s < 0) ? 0 : s;
		hi     = (s + n < lim) ? s + n : lim;
		cursor = clamp_cursor(s + n);
		if (hi <= lo) return 1'b0;
		if (((lo - s) & 1) != 0) begin
			t  = v0;
			v0 = v1;
			v1 = t;
		end
		if (hi - lo == 1) v1 = v0;
		r.kind = KIND_RUN;
		r.addr = lo[19:0];
		r.len  = 8'(hi - lo);
		r.even = v0;
		r.odd  = v1;
		return 1'b1;
	endfunction

	// One stream byte through the decoder model
	function automatic bit decode_byte(logic [7:0] b, logic last, output run_desc_t r);
		bit         bad;
		bit         got;
		logic [7:0] hi_nib;
		logic [7:0] lo_nib;
		bad    = 1'b0;
		got    = 1'b0;
		r      = '0;
		hi_nib = {4'h0, b[7:4]};
		lo_nib = {4'h0, b[3:0]};
		if (done) return 1'b0;
		case (phase)
			P_COUNT: begin
				if (b != RLE_ESCAPE) begin
					if (row < 0) bad = 1'b1;
					else begin
						pend  = b;
						phase = P_COLOR;
					end
				end else phase = P_ESCAPE;
			end
			P_COLOR: begin
				if (nib_mode) got = place_run(pixels_fitting(pend, 1'b1), hi_nib, lo_nib, r);
				else got = place_run(pixels_fitting(pend, 1'b0), b, b, r);
				pend  = 0;
				phase = P_COUNT;
			end
			P_ESCAPE: begin
				if (b == ESC_EOL) begin
					row    = (row - 1 < ROW_SAT) ? ROW_SAT : row - 1;
					cursor = clamp_cursor(row * eff_pitch());
					phase  = P_COUNT;
				end else if (b == ESC_EOB) begin
					done   = 1'b1;
					phase  = P_COUNT;
					r.kind = KIND_END;
					got    = 1'b1;
				end else if (b == ESC_DELTA) begin
					phase = P_DX;
				end else begin
					pend    = b;
					pad_due = nib_mode ? 1'(((int'(b) + 1) >> 1) & 1) : b[0];
					phase   = P_ABS;
				end
			end
			P_DX: begin
				cursor = clamp_cursor(cursor + longint'(b));
				phase  = P_DY;
			end
			P_DY: begin
				cursor = clamp_cursor(cursor - longint'(b) * eff_pitch());
				row    = (row - longint'(b) < ROW_SAT) ? ROW_SAT : row - longint'(b);
				phase  = P_COUNT;
				if (cursor < 0) bad = 1'b1;
			end
			P_ABS: begin
				if (nib_mode && pend >= 2) begin
					got  = place_run(pixels_fitting(2, 1'b1), hi_nib, lo_nib, r);
					pend = pend - 2;
				end else if (nib_mode) begin
					got  = place_run(pixels_fitting(1, 1'b1), hi_nib, hi_nib, r);
					pend = 0;
				end else begin
					got  = place_run(pixels_fitting(1, 1'b0), b, b, r);
					pend = (pend != 0) ? pend - 1 : 0;
				end
				if (pend == 0) phase = pad_due ? P_PAD : P_COUNT;
			end
			P_PAD: begin
				pad_due = 1'b0;
				phase   = P_COUNT;
			end
			default: phase = P_COUNT;
		endcase
		// early end of stream wins over any run from this byte
		if (!done && last) bad = 1'b1;
		if (bad) begin
			done   = 1'b1;
			r      = '0;
			r.kind = KIND_CORRUPT;
			return 1'b1;
		end
		return got;
	endfunction

	function automatic void apply_cfg(logic [1:0] idx, logic [10:0] d);
		case (idx)
			CFG_FOUR_BIT_MODE: nib_mode  = d[0];
			CFG_ROW_PITCH:     pitch_reg = d;
			CFG_FRAME_ROWS:    rows_reg  = d;
			default:           return;
		endcase
		restart_stream();
	endfunction

	function automatic plan_row_t mk_row(logic [7:0] b, bit typed, bit has,
			logic [1:0] kind, logic [19:0] addr, logic [7:0] len, logic [7:0] ev,
			logic [7:0] od);
		plan_row_t p;
		p.b         = b;
		p.last      = 1'b0;
		p.typed     = typed;
		p.has       = has;
		p.want.kind = kind;
		p.want.addr = addr;
		p.want.len  = len;
		p.want.even = ev;
		p.want.odd  = od;
		return p;
	endfunction

	task automatic report(input string what);
		mismatches++;
		if (mismatches <= 40) $display("tb: mismatch at cycle %0d: %s", cycles, what);
	endtask

	// Offer one byte, wait for its transfer, then log what it should produce
	task automatic send_byte(input logic [7:0] b, input logic last, input bit typed,
			input bit typed_has, input run_desc_t typed_r);
		run_desc_t r;
		bit        has;
		bit        live;
		if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		in_valid   <= 1'b1;
		code_byte  <= b;
		stream_end <= last;
		do @(posedge clk); while (!in_ready);
		live = !done;
		has  = decode_byte(b, last, r);
		if (typed) begin
			has = typed_has;
			r   = typed_r;
		end
		if (has) expected_runs.push_back(r);
		if (live) bytes_decoded++;
	endtask

	task automatic push_byte(input logic [7:0] b, input logic last);
		send_byte(b, last, 1'b0, 1'b0, '0);
	endtask

	// Stop offering, wait for every outstanding descriptor plus pipeline slack
	task automatic settle();
		in_valid <= 1'b0;
		while (expected_runs.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic cfg_one(input logic [1:0] idx, input logic [10:0] d);
		cfg_write_en <= 1'b1;
		cfg_index    <= idx;
		cfg_data     <= d;
		@(posedge clk);
		apply_cfg(idx, d);
	endtask

	task automatic write_regs(input bit nib, input logic [10:0] pitch,
			input logic [10:0] rows, input bit stray);
		if (stray) cfg_one(CFG_UNUSED, 11'($urandom));
		cfg_one(CFG_FOUR_BIT_MODE, {10'd0, nib});
		cfg_one(CFG_ROW_PITCH, pitch);
		cfg_one(CFG_FRAME_ROWS, rows);
		cfg_write_en <= 1'b0;
		cfg_sets++;
	endtask

	// Mostly tiny frames so clipping and row underflow come up often
	function automatic logic [10:0] pick_dim();
		int r;
		r = $urandom_range(99);
		if (r < 8) return 11'd0;
		if (r < 16) return 11'd2047;
		if (r < 22) return 11'd1024;
		if (r < 30) return 11'($urandom_range(1, 2047));
		return 11'($urandom_range(1, 10));
	endfunction

	function automatic int pick_count();
		int r;
		r = $urandom_range(99);
		if (r < 70) return $urandom_range(1, 8);
		if (r < 90) return $urandom_range(9, 64);
		return $urandom_range(65, 255);
	endfunction

	// One compressed stream: random commands, then end of bitmap or an early end
	task automatic run_stream(input bit dense);
		int cmds;
		int k;
		int j;
		int n;
		int nbytes;
		int pick;
		int term;
		cmds = dense ? 48 : $urandom_range(2, 24);
		for (k = 0; k < cmds; k++) begin
			pick = dense ? 0 : $urandom_range(99);
			if (pick < 40) begin
				push_byte(8'(pick_count()), 1'b0);
				push_byte(8'($urandom), 1'b0);
			end else if (pick < 65) begin
				n = pick_count();
				if (n < 3) n = 3;
				push_byte(RLE_ESCAPE, 1'b0);
				push_byte(8'(n), 1'b0);
				nbytes = nib_mode ? (n + 1) / 2 : n;
				for (j = 0; j < nbytes; j++) push_byte(8'($urandom), 1'b0);
				if ((nbytes & 1) != 0) push_byte(8'($urandom), 1'b0);
			end else if (pick < 77) begin
				push_byte(RLE_ESCAPE, 1'b0);
				push_byte(ESC_EOL, 1'b0);
			end else if (pick < 87) begin
				push_byte(RLE_ESCAPE, 1'b0);
				push_byte(ESC_DELTA, 1'b0);
				push_byte(($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 7)),
					1'b0);
				push_byte(($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 2)),
					1'b0);
			end else if (pick < 95) begin
				push_byte(8'($urandom), 1'b0);
			end else begin
				push_byte(RLE_ESCAPE, 1'b0);
				push_byte(8'($urandom), 1'b0);
			end
		end
		term = $urandom_range(99);
		if (term < 55) begin
			push_byte(RLE_ESCAPE, 1'b0);
			push_byte(ESC_EOB, 1'b0);
		end else if (term < 70) begin
			push_byte(RLE_ESCAPE, 1'b0);
			push_byte(ESC_EOB, 1'b1);
		end else begin
			repeat ($urandom_range(0, 2)) push_byte(8'($urandom), 1'b0);
			push_byte(8'($urandom), 1'b1);
		end
		// bytes after the stream is closed must be swallowed
		repeat ($urandom_range(0, 2)) push_byte(8'($urandom), 1'($urandom_range(0, 1)));
	endtask

	// Output side: random back-pressure, with one long hold-off on request
	initial begin : receiver
		forever begin
			@(posedge clk);
			if (hold_req) begin
				out_ready <= 1'b0;
				hold_req  <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else out_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Descriptor checking on every output transfer
	always @(posedge clk) begin : check_results
		run_desc_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_runs.size() == 0) begin
				report($sformatf("unexpected descriptor kind %0d addr %0d", result_kind,
					pixel_address));
			end else begin
				want = expected_runs.pop_front();
				if (result_kind !== want.kind)
					report($sformatf("kind %0d, want %0d", result_kind, want.kind));
				if (pixel_address !== want.addr)
					report($sformatf("address %0d, want %0d", pixel_address, want.addr));
				if (run_length !== want.len)
					report($sformatf("length %0d, want %0d", run_length, want.len));
				if (even_value !== want.even)
					report($sformatf("even value %0h, want %0h", even_value, want.even));
				if (odd_value !== want.odd)
					report($sformatf("odd value %0h, want %0h", odd_value, want.odd));
				if (want.kind == KIND_RUN) run_count++;
				else if (want.kind == KIND_END) end_count++;
				else corrupt_count++;
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles == CYCLE_LIMIT) begin
			$display("tb: timeout after %0d cycles", cycles);
			$display("tb: FAIL");
			$finish;
		end
	end

	initial begin : stimulus
		plan_row_t plan[$];
		int        ph;
		int        target;
		bit        held;
		nib_mode  = 1'b0;
		pitch_reg = CFG_DIM_RESET;
		rows_reg  = CFG_DIM_RESET;
		restart_stream();
		held = 1'b0;

		// Directed bytes at the reset setting (RLE8, 1024 x 1024, bottom row 0xFFC00)
		plan.push_back(mk_row(8'h05, 0, 0, KIND_RUN, 0, 0, 0, 0));
		plan.push_back(mk_row(8'hAB, 1, 1, KIND_RUN, 20'hFFC00, 8'd5, 8'hAB, 8'hAB));
		plan.push_back(mk_row(8'hFF, 0, 0, KIND_RUN, 0, 0, 0, 0));
		plan.push_back(mk_row(8'h00, 1, 1, KIND_RUN, 20'hFFC05, 8'd255, 8'h00, 8'h00));
		plan.push_back(mk_row(RLE_ESCAPE, 0, 0, KIND_RUN, 0, 0, 0, 0));
		plan.push_back(mk_row(8'h03, 0, 0, KIND_RUN, 0, 0, 0, 0));
		plan.push_back(mk_row(8'hFF, 1, 1, KIND_RUN, 20'hFFD04, 8'd1, 8'hFF, 8'hFF));
		plan.push_back(mk_row(8'h80, 1, 1, KIND_RUN, 20'hFFD05, 8'd1, 8'h80, 8'h80));
		plan.push_back(mk_row(8'h01, 1, 1, KIND_RUN, 20'hFFD06, 8'd1, 8'h01, 8'h01));
		plan.push_back(mk_row(8'h55, 0, 0, KIND_RUN, 0, 0, 0, 0));
		plan.push_back(mk_row(RLE_ESCAPE, 0, 0, KIND_RUN, 0, 0, 0, 0));
		plan.push_back(mk_row(ESC_DELTA, 0, 0, KIND_RUN, 0, 0, 0, 0));
		plan.push_back(mk_row(8'hFF, 0, 0, KIND_RUN, 0, 0, 0, 0));
		plan.push_back(mk_row(8'h00, 0, 0, KIND_RUN, 0, 0, 0, 0));
		plan.push_back(mk_row(8'h02, 0, 0, KIND_RUN, 0, 0, 0, 0));
		plan.push_back(mk_row(8'hC3, 0, 0, KIND_RUN, 0, 0, 0, 0));
		plan.push_back(mk_row(RLE_ESCAPE, 0, 0, KIND_RUN, 0, 0, 0, 0));
		plan.push_back(mk_row(ESC_EOL, 0, 0, KIND_RUN, 0, 0, 0, 0));
		plan.push_back(mk_row(RLE_ESCAPE, 0, 0, KIND_RUN, 0, 0, 0, 0));
		plan.push_back(mk_row(ESC_DELTA, 0, 0, KIND_RUN, 0, 0, 0, 0));
		plan.push_back(mk_row(8'h00, 0, 0, KIND_RUN, 0, 0, 0, 0));
		plan.push_back(mk_row(8'hFF, 0, 0, KIND_RUN, 0, 0, 0, 0));
		plan.push_back(mk_row(RLE_ESCAPE, 0, 0, KIND_RUN, 0, 0, 0, 0));
		plan.push_back(mk_row(ESC_EOB, 1, 1, KIND_END, 0, 0, 0, 0));
		plan.push_back(mk_row(8'h07, 0, 0, KIND_RUN, 0, 0, 0, 0));
		plan[$].last = 1'b1;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 33;
		recv_idle_pct = 52;
		foreach (plan[i]) send_byte(plan[i].b, plan[i].last, plan[i].typed, plan[i].has,
			plan[i].want);

		// Random streams: receiver-heavy idling, then sender-heavy, then none
		for (ph = 0; ph < 3; ph++) begin
			send_idle_pct = (ph == 0) ? 33 : (ph == 1) ? 52 : 0;
			recv_idle_pct = (ph == 0) ? 52 : (ph == 1) ? 33 : 0;
			target        = bytes_decoded + PHASE_ITEMS;
			while (bytes_decoded < target) begin
				settle();
				if (ph == 2 && !held) begin
					// long output stall with a dense stream so the decoder backs up
					write_regs(1'b0, 11'd1024, 11'd1024, 1'b0);
					hold_req <= 1'b1;
					held = 1'b1;
					run_stream(1'b1);
				end else begin
					write_regs(1'($urandom_range(0, 1)), pick_dim(), pick_dim(),
						$urandom_range(9) == 0);
					run_stream(1'b0);
				end
			end
		end

		settle();
		$display("tb: %0d bytes decoded, %0d runs, %0d end markers, %0d corrupt reports",
			bytes_decoded, run_count, end_count, corrupt_count);
		$display("tb: %0d register settings over RLE8/RLE4 and frames up to 1024x1024",
			cfg_sets);
		if (mismatches == 0) $display("tb: PASS");
		else $display("tb: FAIL");
		$finish;
	end

endmodule

// ===== files.f =====
sv/bmprle_pkg.sv
sv/bmprle_parser.sv
sv/bmp_rle_stream_decoder.sv
tb/tb.sv
